/* rtl/aarf_pkg.sv */
// Shared types and constants for the accumulator ALU and register file block.
package aarf_pkg;

    localparam int REGISTER_COUNT_DEF = 16;
    localparam int IDX_W              = 4;
    localparam int KIND_W             = 4;
    localparam int BYTE_W             = 8;
    localparam int WORD_W             = 16;
    localparam int ADDRESSABLE        = 2 ** IDX_W;
    localparam int S_TDATA_W          = 32;
    localparam int M_TDATA_W          = 24;

    localparam logic [IDX_W-1:0] ACC_IDX = '0;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD  = 4'd0,
        KIND_SUB  = 4'd1,
        KIND_AND  = 4'd2,
        KIND_OR   = 4'd3,
        KIND_XOR  = 4'd4,
        KIND_INC  = 4'd5,
        KIND_DEC  = 4'd6,
        KIND_LOAD = 4'd7,
        KIND_COPY = 4'd8,
        KIND_SWAP = 4'd9
    } kind_t;

    // Zero flag sits in the lowest bit.
    typedef struct packed {
        logic ovf;
        logic carry;
        logic neg;
        logic zero;
    } flags_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] data;
    } wr_port_t;

    // The second write wins where both touch the same register.
    typedef struct packed {
        wr_port_t first;
        wr_port_t second;
    } wr_plan_t;

endpackage

/* rtl/aarf_alu.sv */
// Arithmetic and logic unit with flag generation for 8-bit and 16-bit operations.
module aarf_alu
(
    input  aarf_pkg::kind_t              kind,
    input  logic                         wide,
    input  logic [aarf_pkg::WORD_W-1:0]  a,
    input  logic [aarf_pkg::WORD_W-1:0]  b,
    input  aarf_pkg::flags_t             flags_in,
    output logic [aarf_pkg::WORD_W-1:0]  res,
    output aarf_pkg::flags_t             flags_out
);

    logic [aarf_pkg::WORD_W-1:0] mask;
    logic [aarf_pkg::WORD_W-1:0] opb;
    logic [aarf_pkg::WORD_W:0]   sum;
    logic [aarf_pkg::WORD_W:0]   diff;
    logic [aarf_pkg::WORD_W-1:0] add_res;
    logic [aarf_pkg::WORD_W-1:0] sub_res;
    logic                        sgn_a;
    logic                        sgn_b;
    logic                        sgn_add;
    logic                        sgn_sub;

    assign mask    = wide ? 16'hFFFF : 16'h00FF;
    assign opb     = (kind == aarf_pkg::KIND_INC || kind == aarf_pkg::KIND_DEC) ? 16'd1 : b;
    assign sum     = {1'b0, a} + {1'b0, opb};
    assign diff    = {1'b0, a} - {1'b0, opb};
    assign add_res = sum[aarf_pkg::WORD_W-1:0] & mask;
    assign sub_res = diff[aarf_pkg::WORD_W-1:0] & mask;
    assign sgn_a   = wide ? a[15] : a[7];
    assign sgn_b   = wide ? opb[15] : opb[7];
    assign sgn_add = wide ? add_res[15] : add_res[7];
    assign sgn_sub = wide ? sub_res[15] : sub_res[7];

    always_comb
    begin
        res       = a;
        flags_out = flags_in;
        case (kind)
            aarf_pkg::KIND_ADD, aarf_pkg::KIND_INC:
            begin
                res             = add_res;
                flags_out.carry = wide ? sum[16] : sum[8];
                flags_out.ovf   = (sgn_a ^ sgn_add) & (sgn_b ^ sgn_add);
                flags_out.neg   = sgn_add;
                flags_out.zero  = (add_res == '0);
            end
            aarf_pkg::KIND_SUB, aarf_pkg::KIND_DEC:
            begin
                // Operands never exceed 16 bits, so bit 16 of the difference is the borrow.
                res             = sub_res;
                flags_out.carry = diff[aarf_pkg::WORD_W];
                flags_out.ovf   = (sgn_a ^ sgn_b) & (sgn_a ^ sgn_sub);
                flags_out.neg   = sgn_sub;
                flags_out.zero  = (sub_res == '0);
            end
            aarf_pkg::KIND_AND:
            begin
                res            = a & opb;
                flags_out.zero = ((a & opb) == '0);
            end
            aarf_pkg::KIND_OR:
            begin
                res            = a | opb;
                flags_out.zero = ((a | opb) == '0);
            end
            aarf_pkg::KIND_XOR:
            begin
                res            = a ^ opb;
                flags_out.zero = ((a ^ opb) == '0);
            end
            default:
            begin
                res       = a;
                flags_out = flags_in;
            end
        endcase
    end

endmodule

/* rtl/aarf_regfile.sv */
// Byte register file with three operand read ports and two ordered write ports.
module aarf_regfile
#(
    parameter int REGISTER_COUNT = aarf_pkg::REGISTER_COUNT_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_valid,
    input  aarf_pkg::wr_plan_t           plan,
    input  logic                         wide,
    input  logic [aarf_pkg::IDX_W-1:0]   src_idx,
    input  logic [aarf_pkg::IDX_W-1:0]   dst_idx,
    output logic [aarf_pkg::WORD_W-1:0]  acc_rd,
    output logic [aarf_pkg::WORD_W-1:0]  src_rd,
    output logic [aarf_pkg::WORD_W-1:0]  dst_rd,
    output logic [aarf_pkg::WORD_W-1:0]  acc_next
);

    // Only the first ADDRESSABLE registers can ever be reached by an index.
    localparam int STORE = (REGISTER_COUNT < aarf_pkg::ADDRESSABLE) ?
                           REGISTER_COUNT : aarf_pkg::ADDRESSABLE;

    logic [aarf_pkg::BYTE_W-1:0] regs_reg  [STORE];
    logic [aarf_pkg::BYTE_W-1:0] regs_next [STORE];
    logic [aarf_pkg::BYTE_W-1:0] byte_view [aarf_pkg::ADDRESSABLE];

    function automatic logic [aarf_pkg::BYTE_W-1:0] apply_write(
        input logic [aarf_pkg::BYTE_W-1:0] cur,
        input logic [aarf_pkg::IDX_W-1:0]  pos,
        input aarf_pkg::wr_port_t          port,
        input logic                        is_wide
    );
        logic [aarf_pkg::BYTE_W-1:0] v;
        v = cur;
        if (port.en)
        begin
            if (is_wide)
            begin
                if (pos == {port.idx[aarf_pkg::IDX_W-1:1], 1'b0})
                    v = port.data[15:8];
                else if (pos == {port.idx[aarf_pkg::IDX_W-1:1], 1'b1})
                    v = port.data[7:0];
            end
            else if (pos == port.idx)
            begin
                v = port.data[7:0];
            end
        end
        return v;
    endfunction

    // Registers past the end of the file read as zero.
    for (genvar gi = 0; gi < aarf_pkg::ADDRESSABLE; gi++)
    begin : g_view
        if (gi < STORE)
        begin : g_present
            assign byte_view[gi] = regs_reg[gi];
        end
        else
        begin : g_absent
            assign byte_view[gi] = '0;
        end
    end

    // A wide operand at an odd index uses the pair starting at the even index below.
    assign acc_rd = wide ? {byte_view[{aarf_pkg::ACC_IDX[aarf_pkg::IDX_W-1:1], 1'b0}],
                            byte_view[{aarf_pkg::ACC_IDX[aarf_pkg::IDX_W-1:1], 1'b1}]}
                         : {8'h00, byte_view[aarf_pkg::ACC_IDX]};
    assign src_rd = wide ? {byte_view[{src_idx[aarf_pkg::IDX_W-1:1], 1'b0}],
                            byte_view[{src_idx[aarf_pkg::IDX_W-1:1], 1'b1}]}
                         : {8'h00, byte_view[src_idx]};
    assign dst_rd = wide ? {byte_view[{dst_idx[aarf_pkg::IDX_W-1:1], 1'b0}],
                            byte_view[{dst_idx[aarf_pkg::IDX_W-1:1], 1'b1}]}
                         : {8'h00, byte_view[dst_idx]};

    always_comb
    begin
        for (int i = 0; i < STORE; i++)
        begin
            regs_next[i] = apply_write(
                apply_write(regs_reg[i], aarf_pkg::IDX_W'(i), plan.first, wide),
                aarf_pkg::IDX_W'(i), plan.second, wide);
        end
    end

    assign acc_next = {regs_next[0], regs_next[1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE; i++)
                regs_reg[i] <= '0;
        end
        else if (wr_valid)
        begin
            for (int i = 0; i < STORE; i++)
                regs_reg[i] <= regs_next[i];
        end
    end

endmodule

/* rtl/accumulator_alu_register_file_top.sv */
// Top level of the accumulator execute stage: handshake, operand routing and state update.
//
// The block executes one accumulator-processor operation per input item. Items arrive
// on the s_axis channel and each produces exactly one result item on the m_axis channel,
// carrying the 16-bit accumulator (registers 0 and 1) and the four status flags as they
// stand after that operation.
// An accepted item is held in an input register. From there a single pass of logic reads
// the register file, runs the ALU and forms the register writes; the register file, the
// flags and the output register are then all updated together on the edge where the
// item advances. The result reaches m_axis through the input and output registers, and
// while the receiver takes results a new item can be accepted in every cycle, so the
// sustained rate is one item per cycle, set by the read, compute and write loop on the file.
// When the receiver stalls, the result stays in the output register and the item behind
// it waits in the input register; s_axis_tready drops only when both are full.
// Reset clears every register of the file, the flags and both valid bits; the block is
// ready for an item as soon as reset is released.
module accumulator_alu_register_file_top
#(
    parameter int REGISTER_COUNT = aarf_pkg::REGISTER_COUNT_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // kind[3:0], wide[4], from_register[5], source_register[9:6], dest_register[13:10],
    // memory_operand[29:14], zero padding[31:30]
    input  logic [aarf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // accumulator[15:0], zero_flag[16], negative_flag[17], carry_flag[18],
    // overflow_flag[19], zero padding[23:20]
    output logic [aarf_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    logic                           in_valid_reg;
    logic [aarf_pkg::KIND_W-1:0]    kind_reg;
    logic                           wide_reg;
    logic                           from_register_reg;
    logic [aarf_pkg::IDX_W-1:0]     source_register_reg;
    logic [aarf_pkg::IDX_W-1:0]     dest_register_reg;
    logic [aarf_pkg::WORD_W-1:0]    memory_operand_reg;

    logic                           out_valid_reg;
    logic [aarf_pkg::M_TDATA_W-1:0] out_data_reg;
    aarf_pkg::flags_t               flags_reg;

    logic                           in_accept;
    logic                           advance;
    aarf_pkg::kind_t                kind;
    logic [aarf_pkg::WORD_W-1:0]    mask;
    logic [aarf_pkg::WORD_W-1:0]    mem_masked;
    logic [aarf_pkg::WORD_W-1:0]    acc_rd;
    logic [aarf_pkg::WORD_W-1:0]    src_rd;
    logic [aarf_pkg::WORD_W-1:0]    dst_rd;
    logic [aarf_pkg::WORD_W-1:0]    acc_next;
    logic [aarf_pkg::WORD_W-1:0]    operand_b;
    logic [aarf_pkg::WORD_W-1:0]    alu_res;
    aarf_pkg::flags_t               alu_flags;
    aarf_pkg::wr_plan_t             plan;

    // The item in the input register moves on whenever the output register is free
    // or is being emptied in the same cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg            <= s_axis_tdata[3:0];
            wide_reg            <= s_axis_tdata[4];
            from_register_reg   <= s_axis_tdata[5];
            source_register_reg <= s_axis_tdata[9:6];
            dest_register_reg   <= s_axis_tdata[13:10];
            memory_operand_reg  <= s_axis_tdata[29:14];
        end
    end

    assign kind       = aarf_pkg::kind_t'(kind_reg);
    assign mask       = wide_reg ? 16'hFFFF : 16'h00FF;
    assign mem_masked = memory_operand_reg & mask;
    assign operand_b  = from_register_reg ? src_rd : mem_masked;

    aarf_regfile
    #(
        .REGISTER_COUNT (REGISTER_COUNT)
    )
    u_regfile
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (advance),
        .plan     (plan),
        .wide     (wide_reg),
        .src_idx  (source_register_reg),
        .dst_idx  (dest_register_reg),
        .acc_rd   (acc_rd),
        .src_rd   (src_rd),
        .dst_rd   (dst_rd),
        .acc_next (acc_next)
    );

    aarf_alu u_alu
    (
        .kind      (kind),
        .wide      (wide_reg),
        .a         (acc_rd),
        .b         (operand_b),
        .flags_in  (flags_reg),
        .res       (alu_res),
        .flags_out (alu_flags)
    );

    // Register writes for the operation. Arithmetic and logic write the accumulator,
    // load and copy write the destination, and swap writes both registers with the
    // destination write taking effect last.
    always_comb
    begin
        plan = '0;
        case (kind)
            aarf_pkg::KIND_ADD, aarf_pkg::KIND_SUB, aarf_pkg::KIND_AND,
            aarf_pkg::KIND_OR, aarf_pkg::KIND_XOR, aarf_pkg::KIND_INC,
            aarf_pkg::KIND_DEC:
            begin
                plan.first.en   = 1'b1;
                plan.first.idx  = aarf_pkg::ACC_IDX;
                plan.first.data = alu_res;
            end
            aarf_pkg::KIND_LOAD:
            begin
                plan.first.en   = 1'b1;
                plan.first.idx  = dest_register_reg;
                plan.first.data = mem_masked;
            end
            aarf_pkg::KIND_COPY:
            begin
                plan.first.en   = 1'b1;
                plan.first.idx  = dest_register_reg;
                plan.first.data = src_rd;
            end
            aarf_pkg::KIND_SWAP:
            begin
                plan.first.en    = 1'b1;
                plan.first.idx   = source_register_reg;
                plan.first.data  = dst_rd;
                plan.second.en   = 1'b1;
                plan.second.idx  = dest_register_reg;
                plan.second.data = src_rd;
            end
            default:
            begin
                plan = '0;
            end
        endcase
    end

    // The ALU hands back the old flags for moves and unused kinds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (advance)
        begin
            flags_reg <= alu_flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {4'b0000, alu_flags, acc_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // A finished item always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> out_valid_reg)
        else $error("advanced item did not reach the output register");

    // With both registers full and the receiver stalled, no new item may enter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while pipeline is full and stalled");

    // Flags only change when an item is executed.
    assert property (@(posedge clk) disable iff (!rst_n) !advance |=> $stable(flags_reg))
        else $error("flags changed without an executed item");

    // The reported flags are the state flags right after execution.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_data_reg[19:16] == flags_reg))
        else $error("reported flags differ from the flag register");
`endif

endmodule

/* dv/accumulator_alu_register_file_top_tb.sv */
// Self-checking testbench for the accumulator execute stage with its byte register file.
module accumulator_alu_register_file_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aarf_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_WAIT     = 18;
    localparam int RANDOM_OPS   = 1900;
    // Results pass the input and output registers; the drain then catches stray items.
    localparam int DRAIN_CYCLES = 8;
    // The limit covers the slowest legal run, with every gap and stall at maximum.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    // Kinds above swap are not decoded by the block and must leave everything unchanged.
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = KIND_W'(KIND_SWAP + 1);
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = '1;

    localparam logic [WORD_W-1:0] NARROW_MASK = 16'h00FF;
    localparam logic [WORD_W-1:0] WIDE_MASK   = 16'hFFFF;
    localparam logic [WORD_W-1:0] NARROW_SIGN = 16'h0080;
    localparam logic [WORD_W-1:0] WIDE_SIGN   = 16'h8000;

    // Pacing styles: fully random waits, back to back, or short waits only.
    localparam int PACE_RANDOM = 0;
    localparam int PACE_BURST  = 1;
    localparam int PACE_SHORT  = 2;

    // One instruction as it travels on the input stream.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              wide;
        logic              from_register;
        logic [IDX_W-1:0]  src;
        logic [IDX_W-1:0]  dst;
        logic [WORD_W-1:0] mem;
    } op_item_t;

    // What the block reports after each instruction.
    typedef struct packed {
        logic [WORD_W-1:0] acc;
        flags_t            flags;
    } acc_status_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Shadow copy of the register file and the status flags, advanced in acceptance order.
    logic [BYTE_W-1:0] shadow_regs [REGISTER_COUNT_DEF];
    flags_t            shadow_flags;

    op_item_t    queued_ops[$];
    acc_status_t expected_status[$];

    op_item_t    op_on_bus;
    logic        next_valid;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int          send_pace = PACE_RANDOM;
    int          recv_pace = PACE_RANDOM;
    int unsigned ops_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned op_total = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    accumulator_alu_register_file_top #(
        .REGISTER_COUNT (REGISTER_COUNT_DEF)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // Registers outside the file read as zero and swallow writes.
    function automatic logic [BYTE_W-1:0] reg_read(input int unsigned idx);
        if (idx < REGISTER_COUNT_DEF)
        begin
            return shadow_regs[idx];
        end
        return '0;
    endfunction

    function automatic void reg_write(input int unsigned idx, input logic [BYTE_W-1:0] value);
        if (idx < REGISTER_COUNT_DEF)
        begin
            shadow_regs[idx] = value;
        end
    endfunction

    // A wide operand always lives in the even-aligned pair, high byte at the even index.
    function automatic logic [WORD_W-1:0] operand_read(input int unsigned idx, input logic wide);
        int unsigned base;
        base = idx - (idx % 2);
        if (!wide)
        begin
            return {8'h00, reg_read(idx)};
        end
        return {reg_read(base), reg_read(base + 1)};
    endfunction

    function automatic void operand_write(input int unsigned idx, input logic wide,
                                          input logic [WORD_W-1:0] value);
        int unsigned base;
        base = idx - (idx % 2);
        if (!wide)
        begin
            reg_write(idx, value[BYTE_W-1:0]);
        end
        else
        begin
            reg_write(base, value[WORD_W-1:BYTE_W]);
            reg_write(base + 1, value[BYTE_W-1:0]);
        end
    endfunction

    // Executes one instruction on the shadow state and returns the status the block
    // should report for it.
    function automatic acc_status_t execute_op(input op_item_t op);
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] sign;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] res;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W:0]   total;
        flags_t            f;
        acc_status_t       status;

        mask = op.wide ? WIDE_MASK : NARROW_MASK;
        sign = op.wide ? WIDE_SIGN : NARROW_SIGN;
        a    = operand_read(ACC_IDX, op.wide);
        b    = op.from_register ? operand_read(op.src, op.wide) : (op.mem & mask);
        res  = '0;
        f    = shadow_flags;

        case (op.kind)
            KIND_ADD, KIND_INC:
            begin
                if (op.kind == KIND_INC)
                begin
                    b = WORD_W'(1);
                end
                total   = a + b;
                res     = total[WORD_W-1:0] & mask;
                f       = '0;
                f.carry = (total > mask);
                f.ovf   = |((a ^ res) & (b ^ res) & sign);
            end
            KIND_SUB, KIND_DEC:
            begin
                if (op.kind == KIND_DEC)
                begin
                    b = WORD_W'(1);
                end
                res     = (a - b) & mask;
                f       = '0;
                // Carry holds the borrow here.
                f.carry = (a < b);
                f.ovf   = |((a ^ b) & (a ^ res) & sign);
            end
            KIND_AND: res = a & b;
            KIND_OR:  res = a | b;
            KIND_XOR: res = a ^ b;
            default:  ;
        endcase

        if (op.kind <= KIND_DEC)
        begin
            operand_write(ACC_IDX, op.wide, res);
            // Logic operations keep negative, carry and overflow as they were.
            if (op.kind <= KIND_SUB || op.kind >= KIND_INC)
            begin
                f.neg = |(res & sign);
            end
            f.zero = (res == '0);
            shadow_flags = f;
        end
        else if (op.kind == KIND_LOAD)
        begin
            operand_write(op.dst, op.wide, op.mem & mask);
        end
        else if (op.kind == KIND_COPY)
        begin
            operand_write(op.dst, op.wide, operand_read(op.src, op.wide));
        end
        else if (op.kind == KIND_SWAP)
        begin
            x = operand_read(op.src, op.wide);
            y = operand_read(op.dst, op.wide);
            operand_write(op.src, op.wide, y);
            operand_write(op.dst, op.wide, x);
        end

        status.acc   = {reg_read(ACC_IDX), reg_read(ACC_IDX + 1)};
        status.flags = shadow_flags;
        return status;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_op(input op_item_t op);
        return {2'b00, op.mem, op.dst, op.src, op.from_register, op.wide, op.kind};
    endfunction

    function automatic int unsigned draw_wait(input int pace);
        case (pace)
            PACE_BURST: return 0;
            PACE_SHORT: return $urandom_range(0, 2);
            default:    return $urandom_range(0, MAX_WAIT);
        endcase
    endfunction

    function automatic void queue_op(input logic [KIND_W-1:0] kind, input logic wide,
                                     input logic from_register, input logic [IDX_W-1:0] src,
                                     input logic [IDX_W-1:0] dst, input logic [WORD_W-1:0] mem);
        op_item_t op;
        op.kind          = kind;
        op.wide          = wide;
        op.from_register = from_register;
        op.src           = src;
        op.dst           = dst;
        op.mem           = mem;
        queued_ops.push_back(op);
    endfunction

    // Operands lean toward the sign and carry boundaries so the flags switch often.
    function automatic op_item_t random_op();
        op_item_t    op;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            op.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        end
        else if (pick < 18)
        begin
            op.kind = KIND_LOAD;
        end
        else
        begin
            op.kind = KIND_W'($urandom_range(KIND_ADD, KIND_SWAP));
        end
        op.wide          = 1'($urandom_range(0, 1));
        op.from_register = 1'($urandom_range(0, 1));
        op.src           = IDX_W'($urandom_range(0, ADDRESSABLE - 1));
        op.dst           = IDX_W'($urandom_range(0, ADDRESSABLE - 1));
        if ($urandom_range(0, 9) < 3)
        begin
            case ($urandom_range(0, 7))
                0: op.mem = 16'h0000;
                1: op.mem = 16'hFFFF;
                2: op.mem = 16'h7FFF;
                3: op.mem = 16'h8000;
                4: op.mem = 16'h00FF;
                5: op.mem = 16'h007F;
                6: op.mem = 16'h0080;
                default: op.mem = 16'h0001;
            endcase
        end
        else
        begin
            op.mem = WORD_W'($urandom);
        end
        return op;
    endfunction

    // Compares one result item with the oldest prediction, field by field.
    task automatic check_result(input logic [M_TDATA_W-1:0] beat);
        acc_status_t got;
        acc_status_t want;
        got.acc   = beat[WORD_W-1:0];
        got.flags = beat[WORD_W +: 4];
        if (expected_status.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("unexpected result item: acc=%h z=%b n=%b c=%b v=%b", got.acc,
                         got.flags.zero, got.flags.neg, got.flags.carry, got.flags.ovf);
            end
        end
        else
        begin
            want = expected_status.pop_front();
            if (got.acc !== want.acc || got.flags.zero !== want.flags.zero ||
                got.flags.neg !== want.flags.neg || got.flags.carry !== want.flags.carry ||
                got.flags.ovf !== want.flags.ovf)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display({"result %0d mismatch: acc exp %h got %h, z exp %b got %b, ",
                              "n exp %b got %b, c exp %b got %b, v exp %b got %b"},
                             results_seen, want.acc, got.acc, want.flags.zero, got.flags.zero,
                             want.flags.neg, got.flags.neg, want.flags.carry, got.flags.carry,
                             want.flags.ovf, got.flags.ovf);
                end
            end
        end
    endtask

    // Driver: presents queued instructions, holding each until it is accepted, and runs
    // the shadow model the moment an item is taken so predictions stay in order.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_status.push_back(execute_op(op_on_bus));
                ops_accepted++;
                if (ops_accepted % 50 == 0)
                begin
                    send_pace = $urandom_range(PACE_RANDOM, PACE_SHORT);
                end
            end
            // The valid line is assigned once per edge so a back-to-back item keeps it high.
            if (!s_axis_tvalid || s_axis_tready)
            begin
                next_valid = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (queued_ops.size() > 0)
                begin
                    op_on_bus = queued_ops.pop_front();
                    s_axis_tdata <= pack_op(op_on_bus);
                    next_valid = 1'b1;
                    send_gap = draw_wait(send_pace);
                end
                s_axis_tvalid <= next_valid;
            end
        end
    end

    // Monitor: takes result items and stalls the output between them.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result(m_axis_tdata);
                results_seen++;
                if (results_seen % 40 == 0)
                begin
                    recv_pace = $urandom_range(PACE_RANDOM, PACE_SHORT);
                end
                recv_stall = draw_wait(recv_pace);
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
            end
            m_axis_tready <= (recv_stall == 0);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("accumulator_alu_register_file_top_tb failed");
            $finish;
        end
    end

    initial
    begin
        foreach (shadow_regs[i])
        begin
            shadow_regs[i] = '0;
        end
        shadow_flags = '0;

        // Narrow carry out to zero, then signed overflow on both add and subtract.
        queue_op(KIND_LOAD, 1'b0, 1'b0, 4'd0, 4'd0, 16'h00FF);
        queue_op(KIND_ADD,  1'b0, 1'b0, 4'd0, 4'd0, 16'hFF01);
        queue_op(KIND_LOAD, 1'b0, 1'b0, 4'd0, 4'd0, 16'h007F);
        queue_op(KIND_ADD,  1'b0, 1'b0, 4'd0, 4'd0, 16'h0001);
        queue_op(KIND_SUB,  1'b0, 1'b0, 4'd0, 4'd0, 16'h0001);
        // Wide borrow through zero and back; the load ignores its register-source bit.
        queue_op(KIND_LOAD, 1'b1, 1'b1, 4'd15, 4'd0, 16'h0000);
        queue_op(KIND_DEC,  1'b1, 1'b0, 4'd0, 4'd0, 16'h0000);
        queue_op(KIND_INC,  1'b1, 1'b0, 4'd0, 4'd0, 16'h0000);
        // Wide write to an odd index lands in the pair below it.
        queue_op(KIND_LOAD, 1'b1, 1'b1, 4'd0, 4'd3, 16'hA55A);
        queue_op(KIND_LOAD, 1'b1, 1'b0, 4'd0, 4'd0, 16'h8000);
        queue_op(KIND_SUB,  1'b1, 1'b1, 4'd3, 4'd0, 16'h0000);
        queue_op(KIND_ADD,  1'b1, 1'b0, 4'd0, 4'd0, 16'h7FFF);
        // Wide logic tests all sixteen bits for zero, narrow logic eight; other flags stay.
        queue_op(KIND_AND,  1'b1, 1'b1, 4'd2, 4'd0, 16'h0000);
        queue_op(KIND_XOR,  1'b1, 1'b0, 4'd0, 4'd0, 16'hFFFF);
        queue_op(KIND_OR,   1'b0, 1'b1, 4'd15, 4'd0, 16'h0000);
        queue_op(KIND_XOR,  1'b0, 1'b1, 4'd2, 4'd0, 16'h0000);
        queue_op(KIND_AND,  1'b0, 1'b0, 4'd0, 4'd0, 16'h0000);
        // Moves and unused kinds ignore the register-source bit and leave the flags alone.
        queue_op(KIND_COPY, 1'b1, 1'b0, 4'd2, 4'd5, 16'hFFFF);
        queue_op(KIND_SWAP, 1'b0, 1'b0, 4'd0, 4'd14, 16'h0000);
        queue_op(KIND_SWAP, 1'b1, 1'b1, 4'd0, 4'd5, 16'h0000);
        queue_op(KIND_SWAP, 1'b1, 1'b0, 4'd0, 4'd1, 16'h0000);
        queue_op(KIND_UNUSED_LO, 1'b1, 1'b1, 4'd15, 4'd0, 16'hFFFF);
        queue_op(KIND_UNUSED_HI, 1'b0, 1'b0, 4'd0, 4'd15, 16'h0000);
        queue_op(KIND_LOAD, 1'b0, 1'b0, 4'd0, 4'd1, 16'hFFFF);
        queue_op(KIND_INC,  1'b0, 1'b1, 4'd0, 4'd0, 16'h0000);

        // Random items fill the queue up to the total item count of the run.
        while (queued_ops.size() < RANDOM_OPS)
        begin
            queued_ops.push_back(random_op());
        end
        op_total = queued_ops.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (ops_accepted < op_total || expected_status.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("accumulator_alu_register_file_top_tb passed");
        end
        else
        begin
            $display("accumulator_alu_register_file_top_tb failed");
        end
        $finish;
    end

endmodule
